// ===== rtl/phong_point_light_shader_defines.svh =====
// ----------------------------------------------------------------------------
// Phong shader assertion macros
// Shared concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PHONG_POINT_LIGHT_SHADER_DEFINES_SVH
`define PHONG_POINT_LIGHT_SHADER_DEFINES_SVH
`ifndef SYNTHESIS
// Assert a property on the rising edge of clk_i, idle during reset
`define PPLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Assert that a condition never holds
`define PPLS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PPLS_ASSERT(lbl, prop, msg)
`define PPLS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/ppls_pkg.sv =====
// ----------------------------------------------------------------------------
// Phong shader package
// Widths, latencies, register indexes and payload types of the shader.
// ----------------------------------------------------------------------------
package ppls_pkg;

  localparam int VEC_W     = 16;
  localparam int FRAC      = 14;
  localparam int CLAMP_W   = FRAC + 1;
  localparam int SUM_W     = 2 * VEC_W;
  localparam int SQ_STEPS  = (SUM_W + 2 * FRAC + 2) / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 1;
  localparam int DIV_STEPS = FRAC + 1;
  localparam int NORM_LAT  = 1 + SQ_STEPS + DIV_STEPS + 1;
  localparam int GEO_LAT   = 3;
  localparam int FRONT_LAT = NORM_LAT + GEO_LAT;
  localparam int EXP_W     = 6;
  localparam int POW_STAGES = (1 << EXP_W) - 1;
  localparam int BACK_LAT  = POW_STAGES + 2;
  localparam int Q_DEPTH   = 2;  // power of two
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int CHAN_W    = 8;
  localparam int SHADE_W   = 42;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CLAMP_W-1:0] Q_ONE    = CLAMP_W'(1 << FRAC);
  localparam logic [CHAN_W-1:0]  CHAN_MAX = 8'd255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFL_R   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFL_G   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFL_B   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 3'd6;

  typedef struct packed {
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic signed [VEC_W-1:0] view_x;
    logic signed [VEC_W-1:0] view_y;
    logic signed [VEC_W-1:0] view_z;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec3_t;

  // Clamped dot products handed from front to back
  typedef struct packed {
    logic [CLAMP_W-1:0] diffuse;
    logic [CLAMP_W-1:0] spec_base;
  } geo_t;

  typedef struct packed {
    logic [23:0]      ambient_color;
    logic [23:0]      light_color;
    logic [47:0]      reflect_red;
    logic [47:0]      reflect_green;
    logic [47:0]      reflect_blue;
    logic [EXP_W-1:0] specular_exponent;
  } shade_cfg_t;

endpackage

// ===== rtl/ppls_norm.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined sum of squares, bit-pair square root and restoring division
// producing a Q1.14 unit vector; a zero vector gives zero.
// ----------------------------------------------------------------------------
module ppls_norm (
  input  logic              clk_i,
  input  logic              en_i,
  input  ppls_pkg::vec3_t   vec_i,
  output ppls_pkg::vec3_t   unit_o
);

  localparam int VW = ppls_pkg::VEC_W;
  localparam int SQ = ppls_pkg::SQ_STEPS;
  localparam int DV = ppls_pkg::DIV_STEPS;
  localparam int RW = ppls_pkg::ROOT_W;
  localparam int MW = ppls_pkg::REM_W;
  localparam int FR = ppls_pkg::FRAC;

  logic signed [VW-1:0]        comp [3];
  logic [2:0][VW-1:0]          mag_d;
  logic [2:0]                  neg_d;
  logic [ppls_pkg::SUM_W+1:0]  sum_d;

  logic [ppls_pkg::SUM_W-1:0]  s_q   [0:SQ];
  logic [2:0][VW-1:0]          mag_q [0:SQ];
  logic [2:0]                  neg_q [0:SQ];
  logic [RW-1:0]               root_q [1:SQ];
  logic [MW-1:0]               rem_q  [1:SQ];

  logic [2:0][MW-1:0]          dr_q  [1:DV];
  logic [2:0][DV-1:0]          quo_q [1:DV];
  logic [RW-1:0]               dq_q  [1:DV];
  logic [2:0]                  dn_q  [1:DV];
  logic                        dz_q  [1:DV];

  assign comp[0] = vec_i.x;
  assign comp[1] = vec_i.y;
  assign comp[2] = vec_i.z;

  // Take magnitudes and the sum of squares
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = comp[i][VW-1];
      mag_d[i] = comp[i][VW-1] ? VW'(-comp[i]) : VW'(comp[i]);
      sum_d    = sum_d + (ppls_pkg::SUM_W+2)'(mag_d[i] * mag_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]   <= sum_d[ppls_pkg::SUM_W-1:0];
      mag_q[0] <= mag_d;
      neg_q[0] <= neg_d;
    end
  end

  // Square root of sum * 2^(2*FRAC), one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [RW-1:0]   root_in;
    logic [MW-1:0]   rem_in;
    logic [MW+1:0]   rs;
    logic [MW+1:0]   trial;
    logic [2*SQ-1:0] x;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_rest
      assign root_in = root_q[k];
      assign rem_in  = rem_q[k];
    end

    assign x     = {2'b00, s_q[k], {(2*FR){1'b0}}};
    assign rs    = {rem_in, x[2*SQ-1-2*k -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rs >= trial) begin
          rem_q[k+1]  <= MW'(rs - trial);
          root_q[k+1] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= MW'(rs);
          root_q[k+1] <= {root_in[RW-2:0], 1'b0};
        end
        s_q[k+1]   <= s_q[k];
        mag_q[k+1] <= mag_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // Divide each magnitude * 2^(2*FRAC) by the root, one quotient bit per stage
  for (genvar j = 0; j < DV; j++) begin : g_div
    logic [2:0][MW-1:0] dr_in;
    logic [2:0][DV-1:0] quo_in;
    logic [RW-1:0]      q_in;
    logic [2:0]         neg_in;
    logic               z_in;
    logic [2:0][MW-1:0] dr_nx;
    logic [2:0][DV-1:0] quo_nx;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign dr_in[i] = {{(MW-VW-(FR-1)){1'b0}}, mag_q[SQ][i], {(FR-1){1'b0}}};
      end
      assign quo_in = '0;
      assign q_in   = root_q[SQ];
      assign neg_in = neg_q[SQ];
      assign z_in   = (s_q[SQ] == '0);
    end else begin : g_rest
      assign dr_in  = dr_q[j];
      assign quo_in = quo_q[j];
      assign q_in   = dq_q[j];
      assign neg_in = dn_q[j];
      assign z_in   = dz_q[j];
    end

    always_comb begin
      logic [MW:0] r2;
      for (int i = 0; i < 3; i++) begin
        r2 = {dr_in[i], 1'b0};
        if (r2 >= {1'b0, 1'b0, q_in}) begin
          dr_nx[i]  = MW'(r2 - {1'b0, 1'b0, q_in});
          quo_nx[i] = {quo_in[i][DV-2:0], 1'b1};
        end else begin
          dr_nx[i]  = MW'(r2);
          quo_nx[i] = {quo_in[i][DV-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j+1]  <= dr_nx;
        quo_q[j+1] <= quo_nx;
        dq_q[j+1]  <= q_in;
        dn_q[j+1]  <= neg_in;
        dz_q[j+1]  <= z_in;
      end
    end
  end

  // Clamp, zero the degenerate case and restore the sign
  always_ff @(posedge clk_i) begin
    logic [DV-1:0] n [3];
    logic signed [VW-1:0] u [3];
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        n[i] = (quo_q[DV][i] > ppls_pkg::Q_ONE) ? ppls_pkg::Q_ONE : quo_q[DV][i];
        if (dz_q[DV]) begin
          u[i] = '0;
        end else if (dn_q[DV][i]) begin
          u[i] = -$signed(VW'(n[i]));
        end else begin
          u[i] = $signed(VW'(n[i]));
        end
      end
      unit_o.x <= u[0];
      unit_o.y <= u[1];
      unit_o.z <= u[2];
    end
  end

endmodule

// ===== rtl/ppls_queue.sv =====
// ----------------------------------------------------------------------------
// Front to back queue
// Two-entry FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`include "phong_point_light_shader_defines.svh"

module ppls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ppls_pkg::geo_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ppls_pkg::geo_t  pop_data_o
);

  localparam int PW = ppls_pkg::Q_PTR_W;
  localparam int CW = ppls_pkg::Q_CNT_W;

  ppls_pkg::geo_t  mem_q [ppls_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(ppls_pkg::Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Store a transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PPLS_ASSERT_NEVER(a_cnt_range, cnt_q > CW'(ppls_pkg::Q_DEPTH), "queue count overflow")
  `PPLS_ASSERT(a_push_cnt, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "push not counted")
  `PPLS_ASSERT(a_pop_cnt, pop && !push |=> cnt_q == $past(cnt_q) - 1'b1, "pop not counted")

endmodule

// ===== rtl/ppls_front.sv =====
// ----------------------------------------------------------------------------
// Shader front end
// Normalizes normal and light, forms N.L, the reflection vector and R.V,
// and hands the clamped dot products to the queue.
// ----------------------------------------------------------------------------
module ppls_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppls_pkg::item_t   item_i,
  input  ppls_pkg::vec3_t   light_i,
  output logic              geo_valid_o,
  input  logic              geo_ready_i,
  output ppls_pkg::geo_t    geo_o
);

  localparam int VW = ppls_pkg::VEC_W;
  localparam int FR = ppls_pkg::FRAC;
  localparam int LAT = ppls_pkg::FRONT_LAT;
  localparam int NL = ppls_pkg::NORM_LAT;
  localparam int RW = VW + 4;

  logic                 en;
  logic [LAT-1:0]       vld_q;
  ppls_pkg::vec3_t      normal_in, unit_n, unit_l;
  ppls_pkg::vec3_t      view_q [0:NL-1];

  logic signed [31:0]   d1_q;
  ppls_pkg::vec3_t      n1_q, l1_q, v1_q;
  logic signed [RW-1:0] r2_q [3];
  logic [ppls_pkg::CLAMP_W-1:0] dn2_q;
  ppls_pkg::vec3_t      v2_q;
  logic signed [33:0]   d_sum;
  logic signed [48:0]   pr [3];
  logic signed [39:0]   rv_sum;

  function automatic logic [ppls_pkg::CLAMP_W-1:0] clamp_unit(input logic signed [39:0] d);
    logic signed [39:0] r;
    r = d >>> FR;
    if (d <= 0) begin
      return '0;
    end
    if (r > 40'(ppls_pkg::Q_ONE)) begin
      return ppls_pkg::Q_ONE;
    end
    return ppls_pkg::CLAMP_W'(r);
  endfunction

  assign en          = !vld_q[LAT-1] || geo_ready_i;
  assign in_ready_o  = en;
  assign geo_valid_o = vld_q[LAT-1];

  // Advance the valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign normal_in.x = item_i.normal_x;
  assign normal_in.y = item_i.normal_y;
  assign normal_in.z = item_i.normal_z;

  ppls_norm u_norm_n (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (normal_in),
    .unit_o (unit_n)
  );

  ppls_norm u_norm_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (light_i),
    .unit_o (unit_l)
  );

  // Delay the view vector alongside the normalizers
  always_ff @(posedge clk_i) begin
    if (en) begin
      view_q[0].x <= item_i.view_x;
      view_q[0].y <= item_i.view_y;
      view_q[0].z <= item_i.view_z;
      for (int i = 1; i < NL; i++) begin
        view_q[i] <= view_q[i-1];
      end
    end
  end

  // N.L in Q.28
  always_comb begin
    logic signed [33:0] px, py, pz;
    px = unit_n.x * unit_l.x;
    py = unit_n.y * unit_l.y;
    pz = unit_n.z * unit_l.z;
    d_sum = px + py + pz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q <= 32'(d_sum);
      n1_q <= unit_n;
      l1_q <= unit_l;
      v1_q <= view_q[NL-1];
    end
  end

  // Reflection vector R = 2(N.L)N - L
  always_comb begin
    logic signed [32:0] d2;
    d2 = {d1_q, 1'b0};
    pr[0] = d2 * n1_q.x;
    pr[1] = d2 * n1_q.y;
    pr[2] = d2 * n1_q.z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q[0] <= RW'(pr[0] >>> (2*FR)) - RW'(l1_q.x);
      r2_q[1] <= RW'(pr[1] >>> (2*FR)) - RW'(l1_q.y);
      r2_q[2] <= RW'(pr[2] >>> (2*FR)) - RW'(l1_q.z);
      dn2_q   <= clamp_unit(40'(d1_q));
      v2_q    <= v1_q;
    end
  end

  // R.V, clamped to the unit range
  always_comb begin
    logic signed [39:0] tx, ty, tz;
    tx = r2_q[0] * v2_q.x;
    ty = r2_q[1] * v2_q.y;
    tz = r2_q[2] * v2_q.z;
    rv_sum = tx + ty + tz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_o.diffuse   <= dn2_q;
      geo_o.spec_base <= clamp_unit(rv_sum);
    end
  end

endmodule

// ===== rtl/ppls_back.sv =====
// ----------------------------------------------------------------------------
// Shader back end
// Raises the specular base to the exponent one multiply per stage, then
// sums ambient, diffuse and specular terms per channel and saturates.
// ----------------------------------------------------------------------------
module ppls_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 geo_valid_i,
  output logic                 geo_ready_o,
  input  ppls_pkg::geo_t       geo_i,
  input  ppls_pkg::shade_cfg_t cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppls_pkg::pixel_t     out_data_o
);

  localparam int CW  = ppls_pkg::CLAMP_W;
  localparam int PS  = ppls_pkg::POW_STAGES;
  localparam int LAT = ppls_pkg::BACK_LAT;
  localparam int SW  = ppls_pkg::SHADE_W;
  localparam int FR  = ppls_pkg::FRAC;

  logic              en;
  logic [LAT-1:0]    bv_q;
  logic [CW-1:0]     p_q [1:PS];
  logic [CW-1:0]     s_q [1:PS];
  logic [CW-1:0]     d_q [1:PS];

  logic [7:0]        amb_c [3];
  logic [7:0]        lc_c  [3];
  logic [47:0]       refl_c [3];
  logic [23:0]       ambka_q [3];
  logic [23:0]       lckd_q  [3];
  logic [23:0]       lcks_q  [3];
  logic [SW-1:0]     tot_d [3];
  logic [SW-1:0]     tot_q [3];
  logic [7:0]        chan [3];

  assign en          = !bv_q[LAT-1] || out_ready_i;
  assign geo_ready_o = en;
  assign out_valid_o = bv_q[LAT-1];

  // Advance the valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[LAT-2:0], geo_valid_i};
    end
  end

  // Power by repeated floor multiplication
  for (genvar k = 0; k < PS; k++) begin : g_pow
    logic [CW-1:0]   p_in, s_in, d_in;
    logic [2*CW-1:0] prod;

    if (k == 0) begin : g_first
      assign p_in = ppls_pkg::Q_ONE;
      assign s_in = geo_i.spec_base;
      assign d_in = geo_i.diffuse;
    end else begin : g_rest
      assign p_in = p_q[k];
      assign s_in = s_q[k];
      assign d_in = d_q[k];
    end

    assign prod = p_in * s_in;

    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k+1] <= (cfg_i.specular_exponent > ppls_pkg::EXP_W'(k)) ?
                    CW'(prod >> FR) : p_in;
        s_q[k+1] <= s_in;
        d_q[k+1] <= d_in;
      end
    end
  end

  // Split configuration per channel
  always_comb begin
    amb_c[0]  = cfg_i.ambient_color[23:16];
    amb_c[1]  = cfg_i.ambient_color[15:8];
    amb_c[2]  = cfg_i.ambient_color[7:0];
    lc_c[0]   = cfg_i.light_color[23:16];
    lc_c[1]   = cfg_i.light_color[15:8];
    lc_c[2]   = cfg_i.light_color[7:0];
    refl_c[0] = cfg_i.reflect_red;
    refl_c[1] = cfg_i.reflect_green;
    refl_c[2] = cfg_i.reflect_blue;
  end

  // Hold color-coefficient products; the user must keep them static while items are in flight
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      ambka_q[c] <= amb_c[c] * refl_c[c][47:32];
      lckd_q[c]  <= lc_c[c] * refl_c[c][31:16];
      lcks_q[c]  <= lc_c[c] * refl_c[c][15:0];
    end
  end

  // Sum the three terms in Q.29
  always_comb begin
    logic [SW-1:0] dterm, sterm;
    for (int c = 0; c < 3; c++) begin
      dterm    = lckd_q[c] * d_q[PS];
      sterm    = lcks_q[c] * p_q[PS];
      tot_d[c] = {{(SW-24-FR){1'b0}}, ambka_q[c], {FR{1'b0}}} + dterm + sterm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q <= tot_d;
    end
  end

  // Truncate and saturate
  always_comb begin
    logic [SW-2*FR-2:0] v;
    for (int c = 0; c < 3; c++) begin
      v       = tot_q[c][SW-1:2*FR+1];
      chan[c] = (v > (SW-2*FR-1)'(ppls_pkg::CHAN_MAX)) ? ppls_pkg::CHAN_MAX : v[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.red   <= chan[0];
      out_data_o.green <= chan[1];
      out_data_o.blue  <= chan[2];
    end
  end

endmodule

// ===== rtl/phong_point_light_shader.sv =====
// ----------------------------------------------------------------------------
// Phong point light shader
// One normal and view vector in, one saturated RGB color out.
//
// Input channel in_valid_i/in_ready_o carries item_t; output channel
// out_valid_o/out_ready_i carries pixel_t. Registers are written over
// cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; cfg_ready_o is
// always high. Write registers only while no item is in flight.
// Throughput is one item per cycle while out_ready_i stays high. The
// front has a 48-stage normalizer (one square root bit and one quotient
// bit per stage) and three geometry stages, the queue registers each item,
// and the back has 63 exponent multiply stages, a sum and a saturate stage.
// Reset empties all pipelines and loads register defaults: light
// direction (0,0,1), specular exponent 4, all else zero.
// When the receiver stalls, the back holds, the two-entry queue fills,
// then the front holds and in_ready_o drops.
// ----------------------------------------------------------------------------
module phong_point_light_shader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ppls_pkg::item_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ppls_pkg::pixel_t                    out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppls_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ppls_pkg::shade_cfg_t cfg_q;
  logic [47:0]          light_dir_q;
  ppls_pkg::vec3_t      light;
  logic                 f_valid, f_ready, b_valid, b_ready;
  ppls_pkg::geo_t       f_data, b_data;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ambient_color     <= '0;
      cfg_q.light_color       <= '0;
      cfg_q.reflect_red       <= '0;
      cfg_q.reflect_green     <= '0;
      cfg_q.reflect_blue      <= '0;
      cfg_q.specular_exponent <= ppls_pkg::EXP_W'(4);
      light_dir_q <= 48'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppls_pkg::CFG_AMBIENT:   cfg_q.ambient_color <= cfg_data_i[23:0];
        ppls_pkg::CFG_LIGHT:     cfg_q.light_color   <= cfg_data_i[23:0];
        ppls_pkg::CFG_LIGHT_DIR: light_dir_q         <= cfg_data_i;
        ppls_pkg::CFG_REFL_R:    cfg_q.reflect_red   <= cfg_data_i;
        ppls_pkg::CFG_REFL_G:    cfg_q.reflect_green <= cfg_data_i;
        ppls_pkg::CFG_REFL_B:    cfg_q.reflect_blue  <= cfg_data_i;
        ppls_pkg::CFG_EXPONENT:
          cfg_q.specular_exponent <= cfg_data_i[ppls_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign light.x = light_dir_q[47:32];
  assign light.y = light_dir_q[31:16];
  assign light.z = light_dir_q[15:0];

  ppls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (in_data_i),
    .light_i     (light),
    .geo_valid_o (f_valid),
    .geo_ready_i (f_ready),
    .geo_o       (f_data)
  );

  ppls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  ppls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geo_valid_i (b_valid),
    .geo_ready_o (b_ready),
    .geo_i       (b_data),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Phong shader testbench
// Drives normal and view vectors through the shader under randomized sender
// bursts and receiver stalls, predicts each color in fixed point and checks
// every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_TAIL  = 130;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  ppls_pkg::item_t                 in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  ppls_pkg::pixel_t                out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [ppls_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ppls_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the shader registers
  logic [23:0]                ambient_rgb;
  logic [23:0]                light_rgb;
  logic [47:0]                light_dir;
  logic [47:0]                refl_r, refl_g, refl_b;
  logic [ppls_pkg::EXP_W-1:0] spec_pow;

  ppls_pkg::pixel_t pending_colors[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     burst_left = 0;
  int     gap_max = 0;
  int     stall_pct = 0;
  bit     hold_go = 1'b0;
  int     hold_cnt = 0;

  phong_point_light_shader uut (.*);

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt <= 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each output transfer; signals are stable between edges
  always @(negedge clk_i) begin
    ppls_pkg::pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected color %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        if (want.red !== out_data_o.red) begin
          $display("%0t: red exp %0d got %0d", $time, want.red, out_data_o.red);
          mismatches++;
        end
        if (want.green !== out_data_o.green) begin
          $display("%0t: green exp %0d got %0d", $time, want.green, out_data_o.green);
          mismatches++;
        end
        if (want.blue !== out_data_o.blue) begin
          $display("%0t: blue exp %0d got %0d", $time, want.blue, out_data_o.blue);
          mismatches++;
        end
      end
    end
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint c, longint unsigned q);
    longint unsigned m, n;
    m = (c < 0) ? -c : c;
    n = (m << (2 * ppls_pkg::FRAC)) / q;
    if (n > (64'd1 << ppls_pkg::FRAC)) n = 64'd1 << ppls_pkg::FRAC;
    return (c < 0) ? -longint'(n) : longint'(n);
  endfunction

  // Scale a vector to Q1.14 unit length; zero stays zero
  function automatic void unitize(input longint ax, ay, az,
                                  output longint ux, uy, uz);
    longint unsigned s, q;
    s = longint'(ax * ax + ay * ay + az * az);
    if (s == 0) begin
      ux = 0; uy = 0; uz = 0;
      return;
    end
    q  = isqrt(s << (2 * ppls_pkg::FRAC));
    ux = unit_comp(ax, q);
    uy = unit_comp(ay, q);
    uz = unit_comp(az, q);
  endfunction

  function automatic longint clamp_unit(longint d);
    longint r;
    if (d <= 0) return 0;
    r = d >>> ppls_pkg::FRAC;
    return (r > (1 << ppls_pkg::FRAC)) ? (1 << ppls_pkg::FRAC) : r;
  endfunction

  function automatic logic [7:0] channel_sum(int sh, logic [47:0] refl,
                                             longint unsigned dn, p);
    longint unsigned amb, lc, tot, v;
    amb = (ambient_rgb >> sh) & 8'hFF;
    lc  = (light_rgb >> sh) & 8'hFF;
    tot = ((amb * refl[47:32]) << ppls_pkg::FRAC) + lc * refl[31:16] * dn
          + lc * refl[15:0] * p;
    v   = tot >> (ppls_pkg::FRAC + 15);
    return (v > 255) ? ppls_pkg::CHAN_MAX : v[7:0];
  endfunction

  function automatic ppls_pkg::pixel_t shade_pixel(ppls_pkg::item_t it);
    longint nx, ny, nz, lx, ly, lz, d, dn, s, p, rx, ry, rz;
    ppls_pkg::pixel_t px;
    unitize(it.normal_x, it.normal_y, it.normal_z, nx, ny, nz);
    unitize($signed(light_dir[47:32]), $signed(light_dir[31:16]),
            $signed(light_dir[15:0]), lx, ly, lz);
    d  = nx * lx + ny * ly + nz * lz;
    dn = clamp_unit(d);
    rx = ((2 * d * nx) >>> (2 * ppls_pkg::FRAC)) - lx;
    ry = ((2 * d * ny) >>> (2 * ppls_pkg::FRAC)) - ly;
    rz = ((2 * d * nz) >>> (2 * ppls_pkg::FRAC)) - lz;
    s  = clamp_unit(rx * longint'(it.view_x) + ry * longint'(it.view_y)
                    + rz * longint'(it.view_z));
    p = 1 << ppls_pkg::FRAC;
    for (int e = 0; e < spec_pow; e++) p = (p * s) >>> ppls_pkg::FRAC;
    px.red   = channel_sum(16, refl_r, dn, p);
    px.green = channel_sum(8, refl_g, dn, p);
    px.blue  = channel_sum(0, refl_b, dn, p);
    return px;
  endfunction

  // Send one item in bursts with random gaps; called at a rising edge
  task automatic send_item(ppls_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    pending_colors.push_back(shade_pixel(it));
    @(posedge clk_i);
  endtask

  // Pause input until every expected color has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [ppls_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ppls_pkg::CFG_AMBIENT:   ambient_rgb = val[23:0];
      ppls_pkg::CFG_LIGHT:     light_rgb   = val[23:0];
      ppls_pkg::CFG_LIGHT_DIR: light_dir   = val;
      ppls_pkg::CFG_REFL_R:    refl_r      = val;
      ppls_pkg::CFG_REFL_G:    refl_g      = val;
      ppls_pkg::CFG_REFL_B:    refl_b      = val;
      ppls_pkg::CFG_EXPONENT:  spec_pow    = val[ppls_pkg::EXP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [23:0] amb, logic [23:0] lc, logic [47:0] dir,
                         logic [47:0] rr, rg, rb, logic [ppls_pkg::EXP_W-1:0] ex);
    cfg_write(ppls_pkg::CFG_AMBIENT, amb);
    cfg_write(ppls_pkg::CFG_LIGHT, lc);
    cfg_write(ppls_pkg::CFG_LIGHT_DIR, dir);
    cfg_write(ppls_pkg::CFG_REFL_R, rr);
    cfg_write(ppls_pkg::CFG_REFL_G, rg);
    cfg_write(ppls_pkg::CFG_REFL_B, rb);
    cfg_write(ppls_pkg::CFG_EXPONENT, ex);
  endtask

  function automatic ppls_pkg::item_t make_item(logic [15:0] nx, ny, nz, vx, vy, vz);
    ppls_pkg::item_t it;
    it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
    it.view_x = vx; it.view_y = vy; it.view_z = vz;
    return it;
  endfunction

  // Random item: mostly unit view vectors, sometimes raw 16-bit noise
  function automatic ppls_pkg::item_t rand_item();
    ppls_pkg::item_t it;
    real x, y, z, len;
    int sc;
    sc = $urandom_range(3);
    it.normal_x = (sc == 0) ? $signed(16'($urandom_range(0, 15)) - 16'sd8) : 16'($urandom);
    it.normal_y = (sc == 0) ? $signed(16'($urandom_range(0, 15)) - 16'sd8) : 16'($urandom);
    it.normal_z = (sc == 0) ? $signed(16'($urandom_range(0, 15)) - 16'sd8) : 16'($urandom);
    if ($urandom_range(9) == 0) begin
      it.view_x = 16'($urandom); it.view_y = 16'($urandom); it.view_z = 16'($urandom);
    end else begin
      x = real'(int'($urandom_range(0, 2000)) - 1000);
      y = real'(int'($urandom_range(0, 2000)) - 1000);
      z = real'(int'($urandom_range(0, 2000)) - 1000);
      len = $sqrt(x * x + y * y + z * z);
      if (len == 0.0) begin
        x = 1.0; len = 1.0;
      end
      it.view_x = 16'($rtoi(16384.0 * x / len));
      it.view_y = 16'($rtoi(16384.0 * y / len));
      it.view_z = 16'($rtoi(16384.0 * z / len));
    end
    return it;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Reset defaults: light along z, exponent 4, black everything else
  task automatic test_defaults();
    send_item(make_item(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd16384));
    send_item(make_item(16'sd5, -16'sd3, 16'sd7, 16'sd0, 16'sd16384, 16'sd0));
    drain();
  endtask

  // Field extremes, zero vectors, exponent zero, large constants
  task automatic test_extremes();
    stall_pct = 30;
    gap_max = 3;
    cfg_all(24'hFFFFFF, 24'hFFFFFF, {16'sd0, 16'sd0, 16'sd1},
            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 6'd0);
    send_item(make_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384));
    send_item(make_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd16384, 16'sd16384, 16'sd16384));
    send_item(make_item(16'sh8000, 16'sh8000, 16'sh8000, -16'sd16384, -16'sd16384, -16'sd16384));
    send_item(make_item(16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
    send_item(make_item(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd16384));
    drain();
    cfg_all(24'h102030, 24'hFF8001, 48'd0, 48'h8000_4000_2000,
            48'h0001_FFFF_0000, 48'h0000_0000_FFFF, 6'd63);
    send_item(make_item(16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd0, 16'sd16384));
    send_item(make_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    drain();
    cfg_all(24'h000000, 24'hFFFFFF, {16'sh8000, 16'sh7FFF, 16'sd0},
            48'h0000_8000_8000, 48'h0000_FFFF_FFFF, 48'h0000_0000_8000, 6'd1);
    send_item(make_item(16'sh8000, 16'sh7FFF, 16'sd0, -16'sd11585, 16'sd11585, 16'sd0));
    send_item(make_item(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384));
    send_item(make_item(16'sd1, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0));
    send_item(make_item(16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd16384, 16'sd0));
    send_item(make_item(-16'sd1, 16'sd1, 16'sd0, 16'sd0, -16'sd16384, 16'sd0));
    drain();
    cfg_write(ppls_pkg::CFG_EXPONENT, 6'd0);
  endtask

  // Random phases, each with its own settings and idling pattern
  task automatic test_random();
    int mode;
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      cfg_all(24'($urandom), 24'($urandom),
              (ph == 3) ? 48'd0 : rand48(), rand48(), rand48(), rand48(),
              (mode == 0) ? 6'd0 : (mode == 1) ? 6'd63 : 6'($urandom_range(1, 12)));
      stall_pct = (mode == 2) ? 0 : $urandom_range(0, 70);
      gap_max = (mode == 3) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < 210; k++) begin
        send_item(rand_item());
        if (ph == 5 && k == 100) drain();
      end
      drain();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    stall_pct = 10;
    gap_max = 0;
    @(negedge clk_i);
    hold_go = 1'b1;
    @(posedge clk_i);
    repeat (160) send_item(rand_item());
    drain();
  endtask

  initial begin
    ambient_rgb = '0; light_rgb = '0; light_dir = 48'd1;
    refl_r = '0; refl_g = '0; refl_b = '0; spec_pow = 6'd4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_random();
    test_backpressure();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ppls_pkg.sv
rtl/ppls_norm.sv
rtl/ppls_queue.sv
rtl/ppls_front.sv
rtl/ppls_back.sv
rtl/phong_point_light_shader.sv
dv/tb.sv
